// ===== sv/lfm_pkg.sv =====
`default_nettype none

package lfm_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int MIN_FRAME = 3;

  localparam logic       ACT_BYTE = 1'b0;
  localparam logic       ACT_TICK = 1'b1;

  localparam logic [7:0] BREAK_BYTE = 8'h00;
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] ID_MASK    = 8'h3F;
  localparam logic [7:0] DIAG_ID_A  = 8'h3C;
  localparam logic [7:0] DIAG_ID_B  = 8'h3D;
  localparam logic [8:0] WRAP_MOD   = 9'h0FF;

  localparam logic [1:0] CK_CLASSIC  = 2'd1;
  localparam logic [1:0] CK_ENHANCED = 2'd2;

  localparam logic [15:0] GAP_RESET = 16'd1500;
  localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

  localparam int   ADDR_W   = 3;
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_GAP  = 1'b1;

  typedef struct packed {
    logic idle_clr;
    logic idle_inc;
    logic store_wr;
    logic count_clr;
    logic walk_start;
    logic walk_step;
    logic out_load;
  } lfm_cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic byte_sync;
    logic count_full;
    logic count_zero;
    logic count_short;
    logic gap_hit;
    logic walk_last;
    logic out_free;
  } lfm_stat_t;

endpackage

`default_nettype wire

// ===== sv/lfm_dp.sv =====
`default_nettype none

module lfm_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [1:0]       checksum_mode,
  input  wire logic [15:0]      gap_us,
  input  wire lfm_pkg::lfm_cmd_t cmd,
  output lfm_pkg::lfm_stat_t    stat,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output logic [7:0]            protected_id,
  output logic [3:0]            data_length,
  output logic [63:0]           data_bytes,
  output logic [7:0]            checksum_byte,
  output logic                  pid_ok,
  output logic                  enhanced_match,
  output logic                  checksum_ok,
  output logic                  frame_ok
);
  import lfm_pkg::*;

  function automatic logic [7:0] wrap_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > WRAP_MOD) begin
      s = s - WRAP_MOD;
    end
    return s[7:0];
  endfunction

  logic [15:0]      idle_us;
  logic [15:0]      idle_inc_val;
  logic [CNT_W-1:0] count;
  logic [7:0]       store [FRAME_BYTES];
  logic [7:0]       pid_r;
  logic [7:0]       last_r;
  logic [CNT_W-1:0] dlen;
  logic [IDX_W-1:0] ptr;
  logic [2:0]       pk_idx;
  logic [7:0]       cls;
  logic [7:0]       enh;
  logic [63:0]      packed_data;
  logic [7:0]       walk_byte;

  logic [7:0] classic_sum;
  logic [7:0] enhanced_sum;
  logic [5:0] id;
  logic       p0;
  logic       p1;
  logic       pok;
  logic       diag;
  logic       cmatch;
  logic       ematch;
  logic       cok;

  assign idle_inc_val = (idle_us == IDLE_MAX) ? idle_us : idle_us + 16'd1;
  assign pk_idx       = 3'(ptr - IDX_W'(2));

  assign stat.byte_zero   = (rx_byte == BREAK_BYTE);
  assign stat.byte_sync   = (rx_byte == SYNC_BYTE);
  assign stat.count_full  = (count == CNT_W'(FRAME_BYTES));
  assign stat.count_zero  = (count == '0);
  assign stat.count_short = (count < CNT_W'(MIN_FRAME));
  assign stat.gap_hit     = (idle_inc_val >= gap_us);
  assign stat.walk_last   = (CNT_W'(ptr - IDX_W'(1)) == dlen);
  assign stat.out_free    = !out_valid || !out_stall;

  assign classic_sum  = ~cls;
  assign enhanced_sum = ~enh;
  assign id     = pid_r[5:0];
  assign p0     = id[0] ^ id[1] ^ id[2] ^ id[4];
  assign p1     = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
  assign pok    = (pid_r[6] == p0) && (pid_r[7] == p1);
  assign diag   = ((pid_r & ID_MASK) == DIAG_ID_A) || ((pid_r & ID_MASK) == DIAG_ID_B);
  assign cmatch = (classic_sum == last_r);
  assign ematch = !diag && (enhanced_sum == last_r);

  always_comb begin
    unique case (checksum_mode)
      CK_CLASSIC:  cok = cmatch;
      CK_ENHANCED: cok = ematch;
      default:     cok = cmatch || ematch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_us <= '0;
      count   <= '0;
    end else begin
      if (cmd.idle_clr) begin
        idle_us <= '0;
      end else if (cmd.idle_inc) begin
        idle_us <= idle_inc_val;
      end
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.store_wr) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store[count[IDX_W-1:0]] <= rx_byte;
      last_r <= rx_byte;
      if (count == '0) begin
        pid_r <= rx_byte;
      end
    end
    if (cmd.walk_start) begin
      dlen        <= count - CNT_W'(2);
      ptr         <= IDX_W'(2);
      walk_byte   <= store[IDX_W'(1)];
      cls         <= '0;
      enh         <= pid_r;
      packed_data <= '0;
    end else if (cmd.walk_step) begin
      cls <= wrap_add(cls, walk_byte);
      enh <= wrap_add(enh, walk_byte);
      packed_data[{pk_idx, 3'b000} +: 8] <= walk_byte;
      walk_byte <= store[ptr];
      ptr <= ptr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      protected_id   <= pid_r;
      data_length    <= 4'(dlen);
      data_bytes     <= packed_data;
      checksum_byte  <= last_r;
      pid_ok         <= pok;
      enhanced_match <= ematch;
      checksum_ok    <= cok;
      frame_ok       <= pok && cok;
    end
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> (CNT_W'(ptr - IDX_W'(1)) <= dlen) && (ptr > IDX_W'(1)))
    else $error("walk pointer outside frame data");

  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid && (data_length != 4'd0))
    else $error("result register not loaded");

  a_idle_cmds: assert property (@(posedge clk) disable iff (rst)
    !(cmd.idle_clr && cmd.idle_inc) && !(cmd.store_wr && cmd.count_clr))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== sv/lfm_ctrl.sv =====
`default_nettype none

module lfm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire lfm_pkg::lfm_stat_t stat,
  output lfm_pkg::lfm_cmd_t      cmd
);
  import lfm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LOAD
  } state_t;

  typedef enum logic [1:0] {
    PH_BREAK,
    PH_SYNC,
    PH_COLLECT
  } phase_t;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_BYTE) begin
            cmd.idle_clr = 1'b1;
            unique case (phase)
              PH_SYNC: begin
                if (stat.byte_sync) begin
                  phase_next    = PH_COLLECT;
                  cmd.count_clr = 1'b1;
                end else if (!stat.byte_zero) begin
                  phase_next = PH_BREAK;
                end
              end
              PH_COLLECT: begin
                if (!stat.count_full) begin
                  cmd.store_wr = 1'b1;
                end else begin
                  phase_next    = PH_BREAK;
                  cmd.count_clr = 1'b1;
                end
              end
              default: begin
                phase_next = stat.byte_zero ? PH_SYNC : PH_BREAK;
              end
            endcase
          end else begin
            cmd.idle_inc = 1'b1;
            if (phase == PH_COLLECT && !stat.count_zero && stat.gap_hit) begin
              phase_next    = PH_BREAK;
              cmd.count_clr = 1'b1;
              if (!stat.count_short) begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
              end
            end
          end
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_BREAK;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  a_walk_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_start |=> (state == S_WALK) && (phase == PH_BREAK))
    else $error("frame end did not start the checksum walk");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

  a_busy_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(cmd.store_wr || cmd.idle_inc || cmd.idle_clr))
    else $error("beat taken while walking");

endmodule

`default_nettype wire

// ===== sv/lin_frame_monitor.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | action, rx_byte
// out     | out_valid / out_stall| protected_id, data_length, data_bytes, checksum_byte,
//         |                      | pid_ok, enhanced_match, checksum_ok, frame_ok
// cfg     | APB psel/penable     | checksum_mode at 0x0, gap_us at 0x4
//
// A tick that ends a frame of at least MIN_FRAME bytes starts the checksum walk, which
// reads one stored byte per cycle and then loads the result register.
// The load waits while the result register holds an untaken beat.
// Reset (rst, synchronous) returns to waiting for a break with counters cleared.
// in_stall is high throughout the walk and load.
`default_nettype none

module lin_frame_monitor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lfm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       action,
  input  wire logic [7:0]                 rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      protected_id,
  output logic [3:0]                      data_length,
  output logic [63:0]                     data_bytes,
  output logic [7:0]                      checksum_byte,
  output logic                            pid_ok,
  output logic                            enhanced_match,
  output logic                            checksum_ok,
  output logic                            frame_ok
);
  import lfm_pkg::*;

  logic [1:0]  checksum_mode;
  logic [15:0] gap_us;
  logic        cfg_wr;
  lfm_cmd_t    cmd;
  lfm_stat_t   stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode <= '0;
      gap_us        <= GAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE: checksum_mode <= pwdata[1:0];
        REG_GAP:  gap_us        <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE: prdata = {30'd0, checksum_mode};
      REG_GAP:  prdata = {16'd0, gap_us};
      default:  prdata = '0;
    endcase
  end

  lfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .checksum_mode  (checksum_mode),
    .gap_us         (gap_us),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .protected_id   (protected_id),
    .data_length    (data_length),
    .data_bytes     (data_bytes),
    .checksum_byte  (checksum_byte),
    .pid_ok         (pid_ok),
    .enhanced_match (enhanced_match),
    .checksum_ok    (checksum_ok),
    .frame_ok       (frame_ok)
  );

endmodule

`default_nettype wire

// ===== test/lin_frame_monitor_test.sv =====
`timescale 1ns / 1ps

module lin_frame_monitor_test;
  import lfm_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 29;

  typedef enum logic [1:0] {HUNT_BREAK, HUNT_SYNC, COLLECT} lin_phase_t;

  typedef struct packed {
    logic [7:0]  pid;
    logic [3:0]  dlen;
    logic [63:0] data;
    logic [7:0]  chk;
    logic        pid_good;
    logic        enh;
    logic        cks_good;
    logic        frm_good;
  } lin_rep_t;

  typedef struct packed {
    logic       act;
    logic [7:0] b;
    logic       typed;
    lin_rep_t   rep;
  } lin_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = ACT_BYTE;
  logic [7:0]            rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            protected_id;
  logic [3:0]            data_length;
  logic [63:0]           data_bytes;
  logic [7:0]            checksum_byte;
  logic                  pid_ok;
  logic                  enhanced_match;
  logic                  checksum_ok;
  logic                  frame_ok;

  lin_frame_monitor i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .protected_id   (protected_id),
    .data_length    (data_length),
    .data_bytes     (data_bytes),
    .checksum_byte  (checksum_byte),
    .pid_ok         (pid_ok),
    .enhanced_match (enhanced_match),
    .checksum_ok    (checksum_ok),
    .frame_ok       (frame_ok)
  );

  always #1 clk = ~clk;

  // monitor state and configuration as the bus sees them
  lin_phase_t  bus_phase = HUNT_BREAK;
  int unsigned held_bytes = 0;
  logic [79:0] frame_buf = '0;
  logic [15:0] idle_count = '0;
  logic [1:0]  mode_cfg = '0;
  logic [15:0] gap_cfg = GAP_RESET;

  lin_row_t bus_beats [$];
  lin_rep_t pending_reports [$];
  lin_rep_t head_report;

  int   fails = 0;
  int   cycles = 0;
  int   hold_left = 0;
  logic calm = 1'b0;
  logic squeeze = 1'b0;
  logic squeezed = 1'b0;

  lin_row_t directed_tab [26] = '{
    '{ACT_BYTE, BREAK_BYTE, 1'b0, '0},
    '{ACT_BYTE, SYNC_BYTE,  1'b0, '0},
    '{ACT_BYTE, DIAG_ID_A,  1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'hFF,      1'b0, '0},
    '{ACT_BYTE, 8'h00,      1'b0, '0},
    '{ACT_TICK, 8'h00,      1'b1,
      '{8'h3C, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{ACT_BYTE, BREAK_BYTE, 1'b0, '0},
    '{ACT_BYTE, BREAK_BYTE, 1'b0, '0},
    '{ACT_BYTE, SYNC_BYTE,  1'b0, '0},
    '{ACT_BYTE, 8'h00,      1'b0, '0},
    '{ACT_BYTE, 8'h00,      1'b0, '0},
    '{ACT_BYTE, 8'h00,      1'b0, '0},
    '{ACT_TICK, 8'hFF,      1'b1,
      '{8'h00, 4'd1, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ACT_BYTE, BREAK_BYTE, 1'b0, '0},
    '{ACT_BYTE, SYNC_BYTE,  1'b0, '0},
    '{ACT_TICK, 8'h00,      1'b0, '0},
    '{ACT_BYTE, 8'h12,      1'b0, '0},
    '{ACT_BYTE, 8'h34,      1'b0, '0},
    '{ACT_TICK, 8'h00,      1'b0, '0}
  };

  function automatic logic [7:0] with_parity(logic [5:0] id);
    return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
  endfunction

  function automatic logic [7:0] wrap_sum(logic [7:0] seed, logic [79:0] bytes,
                                          int first, int count);
    int unsigned acc;
    acc = seed;
    for (int k = 0; k < count; k++) begin
      acc += bytes[8*(first+k) +: 8];
      if (acc > 255) acc -= 255;
    end
    return ~acc[7:0];
  endfunction

  function automatic bit decode_beat(logic act, logic [7:0] b, output lin_rep_t rep);
    int unsigned n;
    logic [7:0]  pid;
    bit          diag, cmatch, ematch, cok;
    rep = '0;
    if (act == ACT_BYTE) begin
      idle_count = '0;
      case (bus_phase)
        HUNT_SYNC: begin
          if (b == SYNC_BYTE) begin
            bus_phase = COLLECT;
            held_bytes = 0;
          end else if (b != BREAK_BYTE) begin
            bus_phase = HUNT_BREAK;
          end
        end
        COLLECT: begin
          if (held_bytes < FRAME_BYTES) begin
            frame_buf[8*held_bytes +: 8] = b;
            held_bytes++;
          end else begin
            bus_phase = HUNT_BREAK;
            held_bytes = 0;
          end
        end
        default: bus_phase = (b == BREAK_BYTE) ? HUNT_SYNC : HUNT_BREAK;
      endcase
      return 1'b0;
    end
    if (idle_count != IDLE_MAX) idle_count++;
    if (!(bus_phase == COLLECT && held_bytes > 0 && idle_count >= gap_cfg)) return 1'b0;
    n = held_bytes;
    bus_phase = HUNT_BREAK;
    held_bytes = 0;
    if (n < MIN_FRAME) return 1'b0;
    pid = frame_buf[7:0];
    rep.pid = pid;
    rep.dlen = 4'(n - 2);
    rep.chk = frame_buf[8*(n-1) +: 8];
    for (int k = 0; k < n - 2; k++) rep.data[8*k +: 8] = frame_buf[8*(k+1) +: 8];
    diag = (pid & ID_MASK) == DIAG_ID_A || (pid & ID_MASK) == DIAG_ID_B;
    cmatch = wrap_sum(8'h00, frame_buf, 1, n - 2) == rep.chk;
    ematch = !diag && wrap_sum(pid, frame_buf, 1, n - 2) == rep.chk;
    if (mode_cfg == CK_CLASSIC) cok = cmatch;
    else if (mode_cfg == CK_ENHANCED) cok = ematch;
    else cok = cmatch || ematch;
    rep.pid_good = pid == with_parity(pid[5:0]);
    rep.enh = ematch;
    rep.cks_good = cok;
    rep.frm_good = rep.pid_good && cok;
    return 1'b1;
  endfunction

  task automatic push_beat(logic act, logic [7:0] b);
    lin_row_t row;
    row = '0;
    row.act = act;
    row.b = b;
    bus_beats.push_back(row);
  endtask

  task automatic add_frame(int nbody, int ticks);
    logic [79:0] body;
    logic [7:0]  pid;
    int          pick;
    body = 80'({$urandom, $urandom, $urandom});
    push_beat(ACT_BYTE, BREAK_BYTE);
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0)
      push_beat(ACT_BYTE, BREAK_BYTE);
    push_beat(ACT_BYTE, SYNC_BYTE);
    pick = $urandom_range(0, 9);
    if (pick < 6) pid = with_parity(6'($urandom));
    else if (pick < 8) pid = with_parity(pick[0] ? DIAG_ID_B[5:0] : DIAG_ID_A[5:0]);
    else pid = 8'($urandom);
    body[7:0] = pid;
    if (nbody >= MIN_FRAME && nbody <= FRAME_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) body[8*(nbody-1) +: 8] = wrap_sum(8'h00, body, 1, nbody - 2);
      else if (pick < 8) body[8*(nbody-1) +: 8] = wrap_sum(pid, body, 1, nbody - 2);
    end
    for (int k = 0; k < nbody; k++)
      push_beat(ACT_BYTE, (k < FRAME_BYTES) ? body[8*k +: 8] : 8'($urandom));
    repeat (ticks) push_beat(ACT_TICK, 8'($urandom));
  endtask

  task automatic build_traffic(int target, int maxbody);
    int r, nb, tk;
    while (bus_beats.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if (r < 62) nb = $urandom_range(MIN_FRAME, maxbody);
        else if (r < 70) nb = $urandom_range(0, MIN_FRAME - 1);
        else nb = FRAME_BYTES + 1;
        if ($urandom_range(0, 9) < 8) tk = int'(gap_cfg) + $urandom_range(0, 3);
        else tk = $urandom_range(0, int'(gap_cfg));
        add_frame(nb, tk);
      end else begin
        repeat ($urandom_range(1, 6)) push_beat(1'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODE) mode_cfg = val[1:0];
    else gap_cfg = val[15:0];
  endtask

  task automatic play_beats();
    lin_row_t row;
    lin_rep_t rep;
    bit       made;
    while (bus_beats.size() != 0) begin
      row = bus_beats.pop_front();
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      action <= row.act;
      rx_byte <= row.b;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      made = decode_beat(row.act, row.b, rep);
      if (row.typed) pending_reports.push_back(row.rep);
      else if (made) pending_reports.push_back(rep);
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze && !squeezed) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      squeezed <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with none expected, actual id %0h len %0d data %0h chk %0h",
                 $time, protected_id, data_length, data_bytes, checksum_byte);
        fails++;
      end else begin
        head_report = pending_reports.pop_front();
        check_field("protected_id", 64'(head_report.pid), 64'(protected_id));
        check_field("data_length", 64'(head_report.dlen), 64'(data_length));
        check_field("data_bytes", head_report.data, data_bytes);
        check_field("checksum_byte", 64'(head_report.chk), 64'(checksum_byte));
        check_field("pid_ok", 64'(head_report.pid_good), 64'(pid_ok));
        check_field("enhanced_match", 64'(head_report.enh), 64'(enhanced_match));
        check_field("checksum_ok", 64'(head_report.cks_good), 64'(checksum_ok));
        check_field("frame_ok", 64'(head_report.frm_good), 64'(frame_ok));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_write(REG_GAP, 32'd1);
    foreach (directed_tab[i]) bus_beats.push_back(directed_tab[i]);
    play_beats();
    settle();

    // hold the receiver off while short frames keep coming
    reg_write(REG_MODE, 32'(CK_CLASSIC));
    reg_write(REG_GAP, 32'd2);
    build_traffic(300, MIN_FRAME);
    squeeze <= 1'b1;
    play_beats();
    settle();

    reg_write(REG_MODE, 32'(CK_ENHANCED));
    reg_write(REG_GAP, 32'd5);
    build_traffic(300, FRAME_BYTES);
    play_beats();
    settle();

    reg_write(REG_MODE, 32'd3);
    reg_write(REG_GAP, 32'd0);
    build_traffic(300, FRAME_BYTES);
    play_beats();
    settle();

    reg_write(REG_MODE, 32'd0);
    reg_write(REG_GAP, 32'd1);
    build_traffic(300, FRAME_BYTES);
    calm <= 1'b1;
    play_beats();
    settle();
    calm <= 1'b0;

    reg_write(REG_MODE, 32'($urandom_range(0, 3)));
    reg_write(REG_GAP, 32'($urandom_range(3, 40)));
    build_traffic(200, FRAME_BYTES);
    play_beats();
    settle();

    // widest gap holds a full frame open, then narrow the gap and close it
    reg_write(REG_GAP, 32'(IDLE_MAX));
    add_frame(FRAME_BYTES, 40);
    play_beats();
    settle();
    reg_write(REG_GAP, 32'd1);
    push_beat(ACT_TICK, 8'h00);
    play_beats();
    settle();

    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== lin_frame_monitor.f =====
sv/lfm_pkg.sv
sv/lfm_dp.sv
sv/lfm_ctrl.sv
sv/lin_frame_monitor.sv
test/lin_frame_monitor_test.sv
